### hdl/wfcr_pkg.sv
// Package for the wait FIFO with cancel-remove block.
// Holds the operation and status codes and the control struct broadcast to the cells.
// No dependencies.
`default_nettype none

package wfcr_pkg;

  // Operation codes carried in the input transaction.
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes carried in the result transaction.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Field widths of the stream payloads.
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned NodeIdW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic push_en;    // accepted push with room left
    logic shift_all;  // accepted pop of a non-empty queue
    logic remove_en;  // accepted remove; cells at or after the match shift
  } cell_ctrl_t;

endpackage : wfcr_pkg

`default_nettype wire

### hdl/wfcr_cell.sv
// One storage cell of the wait queue chain.
// Holds one identifier, compares it to the key and shifts from its younger neighbor.
// Depends on wfcr_pkg.
`default_nettype none

module wfcr_cell #(
  parameter int unsigned ID_BITS = 16
) (
  input  wire logic               clk,
  input  wire wfcr_pkg::cell_ctrl_t ctrl,
  input  wire logic [ID_BITS-1:0] key,
  input  wire logic               valid_i,       // this cell holds an entry
  input  wire logic               prev_valid_i,  // older neighbor holds an entry
  input  wire logic               match_i,       // an older cell matched the key
  input  wire logic [ID_BITS-1:0] next_id_i,     // identifier of the younger neighbor
  output logic                    match_o,
  output logic [ID_BITS-1:0]      id_o
);

  import wfcr_pkg::*;

  logic [ID_BITS-1:0] id_r;
  logic [ID_BITS-1:0] id_nxt;
  logic               hit;
  logic               is_tail;

  // Match detection, rippled along the chain so only the oldest match counts.
  assign hit     = valid_i && (id_r == key);
  assign match_o = match_i || hit;
  assign is_tail = !valid_i && prev_valid_i;

  // Push writes the first empty cell; pop and remove move entries one place older.
  always_comb begin
    id_nxt = id_r;
    if (ctrl.push_en && is_tail) begin
      id_nxt = key;
    end else if (ctrl.shift_all || (ctrl.remove_en && match_o)) begin
      id_nxt = next_id_i;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_o = id_r;

endmodule : wfcr_cell

`default_nettype wire

### hdl/wait_fifo_with_cancel_remove.sv
// Top level of the wait FIFO with cancel-remove: cell chain, entry count and result register.
// Depends on wfcr_pkg and wfcr_cell.
//
//   Channel | Direction | tdata fields (low bit first)
//   in_     | slave     | opcode[1:0], node_id[17:2], zero pad[23:18]
//   out_    | master    | status[1:0], out_id[17:2], occupancy[22:18], zero pad[23]
//
// One transaction is taken per cycle while the input is ready.
// The result is held in an output register from the cycle after acceptance.
// The input is ready whenever that register is empty or being drained.
// Match search ripples through the cell chain, which sets the clock period.
// Reset clears the entry count and the result valid flag; stored identifiers keep junk.
`default_nettype none

module wait_fifo_with_cancel_remove #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [wfcr_pkg::InDataW-1:0]  in_tdata,   // opcode, node_id
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [wfcr_pkg::OutDataW-1:0]      out_tdata   // status, out_id, occupancy
);

  import wfcr_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]    count_r;
  logic [CntW-1:0]    count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic [OutDataW-1:0] out_data_nxt;

  logic               accept;
  logic [OpcodeW-1:0] opcode;
  logic [NodeIdW-1:0] node_id;
  logic [31:0]        key_ext;
  logic [ID_BITS-1:0] key;
  logic [31:0]        key_out_ext;
  logic               full;
  logic               empty;
  logic               found;
  cell_ctrl_t         ctrl;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY:0]   match_chain;
  logic [ID_BITS-1:0]  cell_id [CAPACITY];

  logic [StatusW-1:0] status;
  logic [NodeIdW-1:0] res_id;
  logic [31:0]        head_ext;
  logic [31:0]        occ_ext;

  // Input transaction decode.
  assign in_tready   = !out_valid_r || out_tready;
  assign accept      = in_tvalid && in_tready;
  assign opcode      = in_tdata[OpcodeW-1:0];
  assign node_id     = in_tdata[OpcodeW +: NodeIdW];
  assign key_ext     = {16'd0, node_id};
  assign key         = key_ext[ID_BITS-1:0];
  // The identifier as stored, kept to its low ID_BITS bits, for the result field.
  assign key_out_ext = 32'(key);
  assign full        = (count_r == CntW'(CAPACITY));
  assign empty       = (count_r == '0);

  // Broadcast control to the cells.
  always_comb begin
    ctrl.push_en   = accept && (opcode == OP_PUSH) && !full;
    ctrl.shift_all = accept && (opcode == OP_POP) && !empty;
    ctrl.remove_en = accept && (opcode == OP_REMOVE);
  end

  // Chain of cells, oldest entry in cell zero.
  assign match_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_valid;
    logic [ID_BITS-1:0] next_id;

    assign valid[i] = (count_r > CntW'(i));
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_id = '0;
    end else begin : g_mid
      assign next_id = cell_id[i+1];
    end

    wfcr_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .key          (key),
      .valid_i      (valid[i]),
      .prev_valid_i (prev_valid),
      .match_i      (match_chain[i]),
      .next_id_i    (next_id),
      .match_o      (match_chain[i+1]),
      .id_o         (cell_id[i])
    );
  end

  assign found    = match_chain[CAPACITY];
  assign head_ext = 32'(cell_id[0]);

  // Result and entry count for the accepted operation.
  always_comb begin
    status    = ST_OK;
    res_id    = '0;
    count_nxt = count_r;
    case (opcode)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          res_id    = key_out_ext[NodeIdW-1:0];
          count_nxt = count_r + CntW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          res_id    = head_ext[NodeIdW-1:0];
          count_nxt = count_r - CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          res_id    = key_out_ext[NodeIdW-1:0];
          count_nxt = count_r - CntW'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign occ_ext = 32'(count_nxt);

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, occ_ext[OccW-1:0], res_id, status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : wait_fifo_with_cancel_remove

`default_nettype wire
